### sv/hsc_pkg.sv
package hsc_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = 7;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int MIN_LEN = 3;

    // configuration register indexes
    localparam logic REG_ODD_PARITY  = 1'b0;
    localparam logic REG_CODE_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_BEYOND    = 2'd2
    } status_t;

    typedef struct packed {
        logic load;    // store an accepted codeword bit
        logic rd_en;   // read the next held bit
        logic scan;    // the read feeds the syndrome sum
        logic finish;  // close the syndrome and rewind the index
    } cmd_t;

    typedef struct packed {
        logic word_done;
        logic scan_last;
        logic emit_last;
    } sts_t;

endpackage

### sv/hsc_datapath.sv
module hsc_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [hsc_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                      code_bit,
    input  hsc_pkg::cmd_t             cmd,
    output hsc_pkg::sts_t             sts,
    output logic                      corrected_bit,
    output logic [hsc_pkg::LEN_W-1:0] error_position,
    output hsc_pkg::status_t          status
);

    localparam logic [hsc_pkg::LEN_W-1:0] MaxLen = hsc_pkg::LEN_W'(hsc_pkg::MAX_LEN);
    localparam logic [hsc_pkg::LEN_W-1:0] MinLen = hsc_pkg::LEN_W'(hsc_pkg::MIN_LEN);

    logic                      odd_parity_reg;
    logic [hsc_pkg::LEN_W-1:0] code_length_reg;
    logic [hsc_pkg::LEN_W-1:0] bit_count_reg, bit_count_next;
    logic [hsc_pkg::LEN_W-1:0] n_reg, n_next;
    logic [hsc_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic [hsc_pkg::LEN_W-1:0] pos_reg, pos_next;
    logic [hsc_pkg::LEN_W-1:0] acc_reg, acc_next;
    logic [hsc_pkg::LEN_W-1:0] syn_reg, syn_next;
    hsc_pkg::status_t          status_reg, status_next;
    logic                      acc_en_reg;
    logic                      held_q_reg;
    logic                      held_bits_mem [hsc_pkg::MAX_LEN];

    logic [hsc_pkg::LEN_W-1:0] n_eff;
    logic [hsc_pkg::LEN_W-1:0] count_inc;
    logic [hsc_pkg::LEN_W-1:0] syn_final;

    // check bit i exists when 2^i fits in the word
    function automatic logic [hsc_pkg::LEN_W-1:0] check_mask(
        input logic [hsc_pkg::LEN_W-1:0] n
    );
        logic [hsc_pkg::LEN_W-1:0] m;
        m = '0;
        for (int i = 0; i < hsc_pkg::LEN_W; i++)
        begin
            m[i] = ((hsc_pkg::LEN_W+1)'(1) << i) <= {1'b0, n};
        end
        return m;
    endfunction

    always_comb
    begin
        if (code_length_reg < MinLen)
            n_eff = MinLen;
        else if (code_length_reg > MaxLen)
            n_eff = MaxLen;
        else
            n_eff = code_length_reg;
    end

    assign count_inc      = bit_count_reg + hsc_pkg::LEN_W'(1);
    assign sts.word_done  = count_inc >= n_eff;
    assign sts.scan_last  = idx_reg == (n_reg - hsc_pkg::LEN_W'(1));
    assign sts.emit_last  = pos_reg == hsc_pkg::LEN_W'(1);

    assign syn_final = acc_reg ^ (odd_parity_reg ? check_mask(n_reg) : '0);

    always_comb
    begin
        bit_count_next = bit_count_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        syn_next       = syn_reg;
        status_next    = status_reg;

        if (cmd.load)
        begin
            if (sts.word_done)
            begin
                bit_count_next = '0;
                n_next         = n_eff;
                idx_next       = '0;
                acc_next       = '0;
            end
            else
            begin
                bit_count_next = count_inc;
            end
        end

        if (cmd.rd_en)
        begin
            pos_next = n_reg - idx_reg;
            idx_next = idx_reg + hsc_pkg::LEN_W'(1);
        end

        if (acc_en_reg && held_q_reg)
            acc_next = acc_reg ^ pos_reg;

        if (cmd.finish)
        begin
            idx_next = '0;
            syn_next = syn_final;
            if (syn_final == '0)
                status_next = hsc_pkg::ST_NONE;
            else if (syn_final <= n_reg)
                status_next = hsc_pkg::ST_CORRECTED;
            else
                status_next = hsc_pkg::ST_BEYOND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_parity_reg  <= 1'b0;
            code_length_reg <= hsc_pkg::LEN_W'(7);
            bit_count_reg   <= '0;
            n_reg           <= MinLen;
            idx_reg         <= '0;
            pos_reg         <= '0;
            acc_reg         <= '0;
            syn_reg         <= '0;
            status_reg      <= hsc_pkg::ST_NONE;
            acc_en_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && cfg_addr == hsc_pkg::REG_ODD_PARITY)
                odd_parity_reg <= cfg_wdata[0];
            if (cfg_wr_en && cfg_addr == hsc_pkg::REG_CODE_LENGTH)
                code_length_reg <= cfg_wdata;
            bit_count_reg <= bit_count_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            syn_reg       <= syn_next;
            status_reg    <= status_next;
            acc_en_reg    <= cmd.scan;
        end
    end

    // bit store: one write port at load, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load && !bit_count_reg[hsc_pkg::LEN_W-1])
            held_bits_mem[bit_count_reg[hsc_pkg::ADDR_W-1:0]] <= code_bit;
        if (cmd.rd_en)
            held_q_reg <= held_bits_mem[idx_reg[hsc_pkg::ADDR_W-1:0]];
    end

    assign corrected_bit  = held_q_reg ^
                            (status_reg == hsc_pkg::ST_CORRECTED && pos_reg == syn_reg);
    assign error_position = syn_reg;
    assign status         = status_reg;

endmodule

### sv/hsc_ctrl.sv
module hsc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  hsc_pkg::sts_t sts,
    output hsc_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        LOAD,
        SCAN,
        CLOSE,
        FINAL,
        PREP,
        EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            LOAD:
            begin
                cmd.load = in_valid && in_ready_reg;
                if (cmd.load && sts.word_done)
                begin
                    state_next    = SCAN;
                    in_ready_next = 1'b0;
                end
            end
            SCAN:
            begin
                cmd.rd_en = 1'b1;
                cmd.scan  = 1'b1;
                if (sts.scan_last)
                    state_next = CLOSE;
            end
            // last read lands in the sum here
            CLOSE:
            begin
                state_next = FINAL;
            end
            FINAL:
            begin
                cmd.finish = 1'b1;
                state_next = PREP;
            end
            PREP:
            begin
                cmd.rd_en      = 1'b1;
                state_next     = EMIT;
                out_valid_next = 1'b1;
            end
            EMIT:
            begin
                if (out_ready)
                begin
                    if (sts.emit_last)
                    begin
                        state_next     = LOAD;
                        out_valid_next = 1'b0;
                        in_ready_next  = 1'b1;
                    end
                    else
                    begin
                        // fetch the next bit while this one leaves
                        cmd.rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next     = LOAD;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LOAD;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

### sv/hamming_syndrome_corrector.sv
// Channel   Dir  Signals                     Payload
// s_axis    in   tvalid tready tdata[7:0]    code_bit
// m_axis    out  tvalid tready tdata tuser   corrected_bit, error_position, status
//                tlast                       last
// cfg       in   cfg_wr_en cfg_addr cfg_wdata odd_parity, code_length
//
// A word of L bits is loaded bit by bit, scanned once over the bit store's read
// port into the syndrome sum, closed into a syndrome, has its first bit prefetched
// and is then emitted as L corrected bits.
// Input ready drops from the last bit of a word until its last result leaves.
// A stall on m_axis holds the result and the store read in place.
// Reset clears control, counters and syndrome; the bit store has no reset.
module hamming_syndrome_corrector (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [0] code_bit, [7:1] zero
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [0] corrected_bit, [7:1] error_position
    output logic [1:0]                m_axis_tuser,   // [1:0] status
    output logic                      m_axis_tlast,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [hsc_pkg::LEN_W-1:0] cfg_wdata
);

    hsc_pkg::cmd_t             cmd;
    hsc_pkg::sts_t             sts;
    logic                      corrected_bit;
    logic [hsc_pkg::LEN_W-1:0] error_position;
    hsc_pkg::status_t          status;

    hsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hsc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .code_bit       (s_axis_tdata[0]),
        .cmd            (cmd),
        .sts            (sts),
        .corrected_bit  (corrected_bit),
        .error_position (error_position),
        .status         (status)
    );

    assign m_axis_tdata = {error_position, corrected_bit};
    assign m_axis_tuser = status;
    assign m_axis_tlast = sts.emit_last;

endmodule

### sv/hsc_checker.sv
module hsc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [7:0]                s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [7:0]                m_axis_tdata,
    input logic [1:0]                m_axis_tuser,
    input logic                      m_axis_tlast,
    input logic                      cfg_wr_en,
    input logic                      cfg_addr,
    input logic [hsc_pkg::LEN_W-1:0] cfg_wdata
);

    // loading and emitting never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while results pending");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // the word ends with its last bit and input opens again
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("no return to loading after last result");

    // no-error status goes only with a zero syndrome
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == hsc_pkg::ST_NONE |-> m_axis_tdata[7:1] == '0)
        else $error("clean status with nonzero syndrome");

    // error position stays fixed over one word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tdata[7:1] == $past(m_axis_tdata[7:1]) && m_axis_tuser == $past(m_axis_tuser))
        else $error("syndrome changed inside a word");

endmodule

bind hamming_syndrome_corrector hsc_checker u_hsc_checker (.*);

### dv/hamming_syndrome_corrector_tb.sv
module hamming_syndrome_corrector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE      = 8;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_BITS = 250;

    typedef struct {
        logic             bit_out;
        logic [6:0]       position;
        hsc_pkg::status_t status;
        logic             last;
    } emitted_bit_t;

    typedef enum int {
        RX_FREE,
        RX_CHOPPY,
        RX_SLOW
    } rx_mode_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;    // [0] code_bit, [7:1] zero
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;          // [0] corrected_bit, [7:1] error_position
    logic [1:0]                m_axis_tuser;          // [1:0] status
    logic                      m_axis_tlast;
    logic                      cfg_wr_en     = 1'b0;
    logic                      cfg_addr      = 1'b0;
    logic [hsc_pkg::LEN_W-1:0] cfg_wdata     = '0;

    // predictor state, mirrors the block's registers and bit store
    logic             odd_sense = 1'b0;
    logic [6:0]       word_len  = 7'd7;
    int               bits_held = 0;
    logic             held [hsc_pkg::MAX_LEN];

    emitted_bit_t     emit_q [$];
    emitted_bit_t     want_bit;
    int               errors      = 0;
    int               bits_sent   = 0;
    int               burst_left  = 0;
    int               idle_cycles = 0;
    rx_mode_t         rx_mode     = RX_FREE;
    int               rx_left     = 0;

    hamming_syndrome_corrector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // clamp the programmed length to the supported range
    function automatic int span(logic [6:0] len);
        if (len < hsc_pkg::MIN_LEN)
        begin
            return hsc_pkg::MIN_LEN;
        end
        if (len > hsc_pkg::MAX_LEN)
        begin
            return hsc_pkg::MAX_LEN;
        end
        return int'(len);
    endfunction

    // one bit per check group that fits in a word of n bits
    function automatic int check_bits(int n);
        int m;
        int b;
        m = 0;
        b = 1;
        while (b <= n)
        begin
            m |= b;
            b <<= 1;
        end
        return m;
    endfunction

    function automatic void absorb_code_bit(logic b);
        int               n;
        int               s;
        int               k;
        hsc_pkg::status_t st;
        emitted_bit_t     e;
        n = span(word_len);
        if (bits_held < hsc_pkg::MAX_LEN)
        begin
            held[bits_held] = b;
        end
        bits_held++;
        if (bits_held < n)
        begin
            return;
        end
        s = 0;
        for (k = 0; k < n; k++)
        begin
            if (held[k])
            begin
                s ^= n - k;
            end
        end
        if (odd_sense)
        begin
            s ^= check_bits(n);
        end
        s &= 'h7f;
        if (s == 0)
        begin
            st = hsc_pkg::ST_NONE;
        end
        else if (s <= n)
        begin
            st = hsc_pkg::ST_CORRECTED;
        end
        else
        begin
            st = hsc_pkg::ST_BEYOND;
        end
        for (k = 0; k < n; k++)
        begin
            e.bit_out  = held[k] ^ (st == hsc_pkg::ST_CORRECTED && (n - k) == s);
            e.position = 7'(s);
            e.status   = st;
            e.last     = (k == n - 1);
            emit_q.push_back(e);
        end
        bits_held = 0;
    endfunction

    task automatic send_bit(logic b);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_code_bit(b);
        bits_sent++;
        burst_left--;
    endtask

    // send the low n bits of v, highest first
    task automatic send_pattern(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
        begin
            send_bit(v[i]);
        end
    endtask

    // flips < 0 sends pure noise instead of a codeword
    task automatic send_codeword(int n, int flips);
        logic word [1:hsc_pkg::MAX_LEN];
        int   s;
        int   p;
        s = 0;
        for (p = 1; p <= n; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                word[p] = 1'($urandom_range(0, 1));
                if (word[p])
                begin
                    s ^= p;
                end
            end
        end
        if (flips >= 0)
        begin
            // pick check bits so that all checks pass in the current sense
            if (odd_sense)
            begin
                s ^= check_bits(n);
            end
            for (p = 1; p <= n; p <<= 1)
            begin
                word[p] = (s & p) != 0;
            end
            repeat (flips)
            begin
                p = $urandom_range(1, n);
                word[p] = !word[p];
            end
        end
        else
        begin
            for (p = 1; p <= n; p <<= 1)
            begin
                word[p] = 1'($urandom_range(0, 1));
            end
        end
        for (p = n; p >= 1; p--)
        begin
            send_bit(word[p]);
        end
    endtask

    task automatic write_reg(logic addr, logic [6:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (addr == hsc_pkg::REG_ODD_PARITY)
        begin
            odd_sense = data[0];
        end
        else
        begin
            word_len = data;
        end
        @(posedge clk);
    endtask

    // drop the request, wait for every pending result, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (emit_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_default_length_correction();
        // valid word 0110011 with position 5 flipped
        send_pattern(64'b0100011, 7);
        drain();
    endtask

    task automatic test_short_length_odd_parity();
        write_reg(hsc_pkg::REG_ODD_PARITY, 7'd1);
        write_reg(hsc_pkg::REG_CODE_LENGTH, 7'd2);
        send_pattern(64'b000, 3);
        send_pattern(64'b111, 3);
        drain();
    endtask

    task automatic test_syndrome_beyond_length();
        write_reg(hsc_pkg::REG_ODD_PARITY, 7'd0);
        write_reg(hsc_pkg::REG_CODE_LENGTH, 7'd5);
        // ones at positions 5 and 2 point past the word
        send_pattern(64'b10010, 5);
        drain();
    endtask

    task automatic test_length_change_mid_word();
        write_reg(hsc_pkg::REG_CODE_LENGTH, 7'd8);
        send_pattern(64'b10110, 5);
        drain();
        // shrinking below the bits held makes the next bit close the word
        write_reg(hsc_pkg::REG_CODE_LENGTH, 7'd3);
        send_bit(1'b1);
        drain();
    endtask

    task automatic test_random_codewords();
        int         phase;
        int         start;
        int         words;
        int         r;
        int         n;
        logic [6:0] len;
        logic [6:0] odd_val;
        start = bits_sent;
        phase = 0;
        while (bits_sent - start < RANDOM_BITS)
        begin
            case (phase)
                0: len = 7'd64;
                1: len = 7'd127;
                2: len = 7'd0;
                3: len = 7'd3;
                default:
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                    begin
                        len = 7'($urandom_range(65, 127));
                    end
                    else if (r == 1)
                    begin
                        len = 7'($urandom_range(0, 2));
                    end
                    else if (r == 2)
                    begin
                        len = 7'd64;
                    end
                    else
                    begin
                        len = 7'($urandom_range(3, 16));
                    end
                end
            endcase
            odd_val    = 7'($urandom);
            odd_val[0] = (phase == 1 || phase == 2) ||
                         (phase >= 4 && $urandom_range(0, 1) == 1);
            write_reg(hsc_pkg::REG_CODE_LENGTH, len);
            write_reg(hsc_pkg::REG_ODD_PARITY, odd_val);
            n = span(len);
            words = (n > 32) ? 1 : $urandom_range(2, 6);
            repeat (words)
            begin
                r = $urandom_range(0, 9);
                send_codeword(n, (r == 0) ? -1 : (r < 4) ? 0 : (r < 8) ? 1 : 2);
            end
            drain();
            phase++;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_length_correction();
        test_short_length_odd_parity();
        test_syndrome_beyond_length();
        test_length_change_mid_word();
        test_random_codewords();
        drain();
        if (errors == 0)
        begin
            $display("[hamming_syndrome_corrector] OK");
        end
        else
        begin
            $display("[hamming_syndrome_corrector] ERROR");
        end
        $finish;
    end

    // output stalls: switch between free, choppy and slow stretches
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(16, 160);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (emit_q.size() == 0)
            begin
                $error("unexpected result: tdata=%h tuser=%h tlast=%b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                want_bit = emit_q.pop_front();
                if (m_axis_tdata[0] !== want_bit.bit_out)
                begin
                    $error("corrected_bit: expected %0b, got %0b",
                           want_bit.bit_out, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[7:1] !== want_bit.position)
                begin
                    $error("error_position: expected %0d, got %0d",
                           want_bit.position, m_axis_tdata[7:1]);
                    errors++;
                end
                if (m_axis_tuser !== want_bit.status)
                begin
                    $error("status: expected %0d, got %0d", want_bit.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== want_bit.last)
                begin
                    $error("last: expected %0b, got %0b", want_bit.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("[hamming_syndrome_corrector] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
